>>> hdl/imutm_pkg.sv
// ----------------------------------------------------------------------------
// imutm_pkg: shared types and constants
// sample widths, stream packing and the control bundle of the imu filter
// ----------------------------------------------------------------------------
package imutm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int NUM_AXES  = 6;
  localparam int NUM_ACCEL = 3;
  localparam int TDATA_W   = SAMPLE_W * NUM_AXES;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_APPLY_ACCEL = 1'b0,
    CFG_APPLY_GYRO  = 1'b1
  } cfg_reg_t;

  // load enables for the history line and the per-axis pipeline stages
  typedef struct packed {
    logic hist_shift;
    logic ld_win;
    logic ld_sum;
    logic ld_mag;
    logic ld_prod;
    logic ld_out;
  } imutm_ctrl_t;

endpackage

>>> hdl/imutm_axis.sv
// ----------------------------------------------------------------------------
// imutm_axis: one axis of the trimmed-mean filter
// sample history, window min/max/sum tree, constant divide and output select
// ----------------------------------------------------------------------------
module imutm_axis
  import imutm_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic                       clk,
  input  imutm_ctrl_t                ctrl,
  input  logic                       sel_filt,
  input  logic signed [SAMPLE_W-1:0] din,
  output logic signed [SAMPLE_W-1:0] dout
);

  localparam int HIST_LEN = WINDOW_LEN - 1;
  localparam int DIV      = WINDOW_LEN - 2;
  localparam int LVLS     = $clog2(WINDOW_LEN);
  localparam int TREE_N   = 1 << LVLS;
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int MAG_W    = SAMPLE_W - 1 + $clog2(DIV + 1);
  // reciprocal with enough fraction bits that floor(mag * RECIP >> SHIFT) is exact
  localparam int SHIFT    = MAG_W + $clog2(DIV);
  localparam int RECIP_W  = SHIFT + 1;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W   = MAG_W + RECIP_W;

  logic signed [SAMPLE_W-1:0] hist [HIST_LEN];
  logic signed [SAMPLE_W-1:0] win  [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] raw_win, raw_sum, raw_mag, raw_prod;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] mx_r, mn_r;
  logic                       neg_mag, neg_prod;
  logic [MAG_W-1:0]           mag_r;
  logic [PROD_W-1:0]          prod_r;

  logic signed [SAMPLE_W-1:0] mx_t [TREE_N];
  logic signed [SAMPLE_W-1:0] mn_t [TREE_N];
  logic signed [SUM_W-1:0]    sm_t [TREE_N];
  logic signed [SUM_W-1:0]    trim;
  logic [SUM_W-1:0]           trim_abs;
  logic [SAMPLE_W-1:0]        quot;
  logic signed [SAMPLE_W-1:0] filt;

  // history line, oldest at index 0
  always_ff @(posedge clk) begin
    if (ctrl.hist_shift) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HIST_LEN-1] <= din;
    end
  end

  // window snapshot
  always_ff @(posedge clk) begin
    if (ctrl.ld_win) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        win[i] <= hist[i];
      end
      win[WINDOW_LEN-1] <= din;
      raw_win <= din;
    end
  end

  // pairwise max / min / sum tree, padded to a power of two
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < WINDOW_LEN) begin
        mx_t[i] = win[i];
        mn_t[i] = win[i];
        sm_t[i] = SUM_W'(win[i]);
      end else begin
        mx_t[i] = win[0];
        mn_t[i] = win[0];
        sm_t[i] = '0;
      end
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        mx_t[i] = (mx_t[2*i] > mx_t[2*i+1]) ? mx_t[2*i] : mx_t[2*i+1];
        mn_t[i] = (mn_t[2*i] < mn_t[2*i+1]) ? mn_t[2*i] : mn_t[2*i+1];
        sm_t[i] = sm_t[2*i] + sm_t[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      sum_r   <= sm_t[0];
      mx_r    <= mx_t[0];
      mn_r    <= mn_t[0];
      raw_sum <= raw_win;
    end
  end

  // trimmed sum as sign and magnitude
  always_comb begin
    trim     = sum_r - SUM_W'(mx_r) - SUM_W'(mn_r);
    trim_abs = trim[SUM_W-1] ? SUM_W'(-trim) : SUM_W'(trim);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_mag) begin
      neg_mag <= trim[SUM_W-1];
      mag_r   <= trim_abs[MAG_W-1:0];
      raw_mag <= raw_sum;
    end
  end

  // divide by the constant via reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      prod_r   <= PROD_W'(mag_r) * PROD_W'(RECIP);
      neg_prod <= neg_mag;
      raw_prod <= raw_mag;
    end
  end

  // truncation toward zero: negate the floored magnitude
  always_comb begin
    quot = prod_r[SHIFT +: SAMPLE_W];
    filt = neg_prod ? -$signed(quot) : $signed(quot);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      dout <= sel_filt ? filt : raw_prod;
    end
  end

endmodule

>>> hdl/imu_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// imu_trimmed_mean_filter: six-axis trimmed-mean moving filter
// per-axis sliding window, drops max and min, averages the rest
// ----------------------------------------------------------------------------
// One transaction carries a six-axis sample and yields one result transaction.
// The block takes a sample every cycle: five register stages (window snapshot,
// min/max/sum tree, trim, reciprocal multiply, output) each hold one sample and
// move on independently, so a stalled output only blocks the input once all
// five stages are full. The first WINDOW_LEN-1 samples after reset fill the
// history and come out raw with the filtered flag low. From then on each axis
// gives the sum of its newest WINDOW_LEN samples less their maximum and minimum,
// divided by WINDOW_LEN-2 with truncation toward zero, and the flag is high.
// apply_accel and apply_gyro select filtered or raw output per sensor; the
// history updates either way. Write the configuration only while the block is
// idle.
// ----------------------------------------------------------------------------
module imu_trimmed_mean_filter
  import imutm_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic               clk,
  input  logic               rst,
  // input sample stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // out_accel_x .. out_gyro_z, same order as input
  output logic               m_tuser,   // filtered
  // configuration writes
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [0:0]         cfg_wdata
);

  localparam int HIST_LEN = WINDOW_LEN - 1;
  localparam int CNT_W    = $clog2(WINDOW_LEN);

  logic             apply_accel, apply_gyro;
  logic [CNT_W-1:0] fill_count;
  logic             full;

  // stage valids and filtered flags
  logic v_win, v_sum, v_mag, v_prod;
  logic f_win, f_sum, f_mag, f_prod;
  logic rdy_out, rdy_prod, rdy_mag, rdy_sum, rdy_win;
  logic accept;

  imutm_ctrl_t ctrl;
  logic        sel_accel, sel_gyro;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      apply_accel <= 1'b1;
      apply_gyro  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_APPLY_ACCEL: apply_accel <= cfg_wdata[0];
        CFG_APPLY_GYRO:  apply_gyro  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a stage can load when it is empty or its contents move on this cycle
  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy_prod = !v_prod || rdy_out;
  assign rdy_mag  = !v_mag  || rdy_prod;
  assign rdy_sum  = !v_sum  || rdy_mag;
  assign rdy_win  = !v_win  || rdy_sum;
  assign s_tready = rdy_win;
  assign accept   = s_tvalid && s_tready;

  assign full = (fill_count == CNT_W'(HIST_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept && !full) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v_win    <= 1'b0;
      v_sum    <= 1'b0;
      v_mag    <= 1'b0;
      v_prod   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy_win)  v_win    <= s_tvalid;
      if (rdy_sum)  v_sum    <= v_win;
      if (rdy_mag)  v_mag    <= v_sum;
      if (rdy_prod) v_prod   <= v_mag;
      if (rdy_out)  m_tvalid <= v_prod;
    end
  end

  // filtered flag travels with its sample
  always_ff @(posedge clk) begin
    if (ctrl.ld_win)  f_win   <= full;
    if (ctrl.ld_sum)  f_sum   <= f_win;
    if (ctrl.ld_mag)  f_mag   <= f_sum;
    if (ctrl.ld_prod) f_prod  <= f_mag;
    if (ctrl.ld_out)  m_tuser <= f_prod;
  end

  always_comb begin
    ctrl.hist_shift = accept;
    ctrl.ld_win     = accept;
    ctrl.ld_sum     = v_win  && rdy_sum;
    ctrl.ld_mag     = v_sum  && rdy_mag;
    ctrl.ld_prod    = v_mag  && rdy_prod;
    ctrl.ld_out     = v_prod && rdy_out;
  end

  // raw output during fill, whatever the apply bits say
  assign sel_accel = f_prod && apply_accel;
  assign sel_gyro  = f_prod && apply_gyro;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    imutm_axis #(
      .WINDOW_LEN (WINDOW_LEN)
    ) u_axis (
      .clk      (clk),
      .ctrl     (ctrl),
      .sel_filt ((a < NUM_ACCEL) ? sel_accel : sel_gyro),
      .din      (s_tdata[a*SAMPLE_W +: SAMPLE_W]),
      .dout     (m_tdata[a*SAMPLE_W +: SAMPLE_W])
    );
  end

`ifndef SYNTHESIS
  // a filtered result cannot exist before the history is complete
  a_filtered_after_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> full)
    else $error("filtered result seen before history was full");

  // input back-pressure only when every stage holds a sample
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v_win && v_sum && v_mag && v_prod && m_tvalid)
    else $error("input stalled with an empty pipeline stage");

  // fill counter saturates and stays there
  a_fill_saturates: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("fill count left its saturated value");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the imu trimmed-mean filter
// drives six-axis samples under random source gaps and sink stalls, predicts
// each result from a local copy of the per-axis history and compares fields
// ----------------------------------------------------------------------------
module tb
  import imutm_pkg::*;
();

  localparam int WIN      = 5;
  localparam int HIST     = WIN - 1;
  localparam int IDLE_PCT = 17;

  typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] six_axis_t;

  typedef struct packed {
    logic      filtered;
    six_axis_t axes;
  } filt_result_t;

  // directed stimulus row, result typed in where it is obvious
  typedef struct packed {
    six_axis_t    smp;
    logic         known;
    filt_result_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;       // out_accel_x .. out_gyro_z
  logic               m_tuser;       // filtered
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = CFG_APPLY_ACCEL;
  logic [0:0]         cfg_wdata = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  imu_trimmed_mean_filter #(
    .WINDOW_LEN (WIN)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // predictor state: per-axis history, fill level and the two enables
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] win_hist [NUM_AXES][HIST];
  int unsigned                fill_cnt = 0;
  bit                         use_acc_filt = 1'b1;
  bit                         use_gyr_filt = 1'b1;

  filt_result_t filter_out_q[$];   // results still owed by the block
  dir_row_t     dir_tab[$];
  int           drift [NUM_AXES];  // slow-moving base for sensor-like samples

  string axis_names [NUM_AXES] = '{"out_accel_x", "out_accel_y", "out_accel_z",
                                   "out_gyro_x", "out_gyro_y", "out_gyro_z"};

  bit quiet_run = 1'b0;            // no gaps and no stalls on either side
  int n_err = 0, n_sent = 0, n_results = 0, n_filtered = 0, n_fill = 0;

  // one accepted sample: fill the history, or trim and average the window
  function automatic filt_result_t trimmed_mean_step(six_axis_t smp);
    filt_result_t r;
    int v, mx, mn, sum, tm;
    bit use_filt;
    r.axes = smp;
    if (fill_cnt < HIST) begin
      for (int a = 0; a < NUM_AXES; a++) win_hist[a][fill_cnt] = smp[a];
      fill_cnt++;
      r.filtered = 1'b0;
      return r;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      mx  = -32769;
      mn  = 32768;
      sum = 0;
      for (int i = 0; i < WIN; i++) begin
        if (i < HIST) v = win_hist[a][i];
        else          v = $signed(smp[a]);
        if (v > mx) mx = v;
        if (v < mn) mn = v;
        sum += v;
      end
      // integer division truncates toward zero, as the block does
      tm = (sum - mx - mn) / (WIN - 2);
      for (int i = 0; i + 1 < HIST; i++) win_hist[a][i] = win_hist[a][i+1];
      win_hist[a][HIST-1] = smp[a];
      use_filt  = (a < NUM_ACCEL) ? use_acc_filt : use_gyr_filt;
      r.axes[a] = use_filt ? tm[SAMPLE_W-1:0] : smp[a];
    end
    r.filtered = 1'b1;
    return r;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767)  return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic six_axis_t axes6(int a0, int a1, int a2, int a3, int a4, int a5);
    six_axis_t s;
    s[0] = a0[15:0]; s[1] = a1[15:0]; s[2] = a2[15:0];
    s[3] = a3[15:0]; s[4] = a4[15:0]; s[5] = a5[15:0];
    return s;
  endfunction

  function automatic six_axis_t splat(int v);
    return axes6(v, v, v, v, v, v);
  endfunction

  function automatic void add_row(six_axis_t smp, logic known, filt_result_t res);
    dir_row_t row;
    row.smp   = smp;
    row.known = known;
    row.res   = res;
    dir_tab.push_back(row);
  endfunction

  // mostly smooth sensor-like data with outliers, plus raw noise and extremes
  function automatic six_axis_t draw_sample();
    six_axis_t s;
    int mode, v;
    mode = $urandom_range(99);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (mode < 60) begin
        drift[a] = clamp16(drift[a] + int'($urandom_range(600)) - 300);
        v = drift[a] + int'($urandom_range(64)) - 32;
        if ($urandom_range(9) == 0) v += $urandom_range(1) ? 15000 : -15000;
        v = clamp16(v);
      end else if (mode < 75) begin
        v = int'($urandom_range(16'hFFFF));
      end else if (mode < 85) begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end else begin
        // clusters near the rails
        v = $urandom_range(1) ? 32767 - int'($urandom_range(40))
                              : -32768 + int'($urandom_range(40));
      end
      s[a] = v[15:0];
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // source side: one sample per transaction, random idle cycles in between
  // --------------------------------------------------------------------------
  task automatic push_sample(six_axis_t smp, logic known, filt_result_t res);
    filt_result_t want;
    // each cycle idles with the same odds, so short gaps are more common than long ones
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // transaction taken at this edge
    want = trimmed_mean_step(smp);
    filter_out_q.push_back(known ? res : want);
    n_sent++;
  endtask

  // enables are written only once the pipeline has drained
  task automatic write_enables(bit acc, bit gyr);
    s_tvalid <= 1'b0;
    while (filter_out_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_APPLY_ACCEL;
    cfg_wdata <= acc;
    @(posedge clk);
    use_acc_filt = acc;
    cfg_index <= CFG_APPLY_GYRO;
    cfg_wdata <= gyr;
    @(posedge clk);
    use_gyr_filt = gyr;
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      // long stretch with no idling on either side
      quiet_run = (n_sent >= 300 && n_sent < 420);
      push_sample(draw_sample(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // sink side: random stalls, every result compared with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    filt_result_t want;
    m_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser) n_filtered++;
      else         n_fill++;
      if (filter_out_q.size() == 0) begin
        $error("result transaction with no sample pending: m_tdata=%h", m_tdata);
        n_err++;
      end else begin
        want = filter_out_q.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (m_tdata[a*SAMPLE_W +: SAMPLE_W] !== want.axes[a]) begin
            $error("%s: expected %0d, got %0d", axis_names[a], $signed(want.axes[a]),
                   $signed(m_tdata[a*SAMPLE_W +: SAMPLE_W]));
            n_err++;
          end
        end
        if (m_tuser !== want.filtered) begin
          $error("filtered: expected %0b, got %0b", want.filtered, m_tuser);
          n_err++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    filt_result_t r;
    for (int a = 0; a < NUM_AXES; a++) drift[a] = 0;

    // fill phase: raw out, flag low, whatever the enables hold
    r.filtered = 1'b0;
    r.axes = splat(32767);                           add_row(r.axes, 1'b1, r);
    r.axes = splat(-32768);                          add_row(r.axes, 1'b1, r);
    r.axes = axes6(0, -1, 1, 16'h5555, 16'hAAAA, 16'h8001);
    add_row(r.axes, 1'b1, r);
    r.axes = axes6(32766, 1, -2, 0, -32768, 32767);  add_row(r.axes, 1'b1, r);
    // first filtered sample, mixed window
    add_row(axes6(100, -100, 7, -7, 32767, -32768), 1'b0, '0);
    // window of all maximum, then of all minimum
    repeat (4) add_row(splat(32767), 1'b0, '0);
    r.filtered = 1'b1;
    r.axes = splat(32767);                           add_row(r.axes, 1'b1, r);
    repeat (4) add_row(splat(-32768), 1'b0, '0);
    r.axes = splat(-32768);                          add_row(r.axes, 1'b1, r);
    // small negative sums: truncation toward zero
    add_row(axes6(-1, -2, -3, 1, 2, -7), 1'b0, '0);
    add_row(axes6(-2, 0, -5, 2, 3, -1), 1'b0, '0);
    add_row(axes6(-4, -1, 2, 0, -9, -3), 1'b0, '0);
    add_row(axes6(-1, -1, -1, -2, 1, -2), 1'b0, '0);
    add_row(axes6(0, -2, -1, -1, -1, -5), 1'b0, '0);
    // alternating rails
    add_row(axes6(32767, -32768, 32767, -32768, 32767, -32768), 1'b0, '0);
    add_row(axes6(-32768, 32767, -32768, 32767, -32768, 32767), 1'b0, '0);
    add_row(axes6(32767, -32768, 32767, -32768, 32767, -32768), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_enables(1'b1, 1'b1);
    foreach (dir_tab[i]) push_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].res);

    // both raw, each sensor alone, then both filtered again
    write_enables(1'b0, 1'b0);
    run_random(140);
    write_enables(1'b1, 1'b0);
    run_random(140);
    write_enables(1'b0, 1'b1);
    run_random(140);
    write_enables(1'b1, 1'b1);
    run_random(230);

    s_tvalid <= 1'b0;
    while (filter_out_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d samples sent, %0d results checked (%0d fill, %0d filtered)",
             n_sent, n_results, n_fill, n_filtered);
    $display("enable settings visited: 11, 00, 10, 01, 11; %0d mismatches", n_err);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
